// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- hw/rtl/dsa_pkg.sv -----
`default_nettype none

package dsa_pkg;

  localparam int MaxDigits  = 255;
  localparam int ChainDepth = MaxDigits + 1;
  localparam int WordDigits = 16;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] len_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_UP,
    SHIFT_DOWN
  } shift_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    shift_e mode;
    digit_t lo_in;
    digit_t hi_in;
  } chain_ctrl_t;

  typedef struct packed {
    logic   operand_select;
    digit_t digit;
    logic   last_digit;
  } in_t;

  typedef struct packed {
    logic [63:0] sum_digits_bcd;
    logic [4:0]  digit_count;
    logic        last_word;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dsa_cell.sv -----
`default_nettype none

module dsa_cell (
  input  wire              clk_i,
  input  dsa_pkg::shift_e  mode_i,
  input  dsa_pkg::digit_t  from_lo_i,
  input  dsa_pkg::digit_t  from_hi_i,
  output dsa_pkg::digit_t  digit_o
);

  dsa_pkg::digit_t digit_q, digit_d;

  always_comb begin
    unique case (mode_i)
      dsa_pkg::SHIFT_UP:   digit_d = from_lo_i;
      dsa_pkg::SHIFT_DOWN: digit_d = from_hi_i;
      default:             digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dsa_chain.sv -----
`default_nettype none

module dsa_chain (
  input  wire                  clk_i,
  input  dsa_pkg::chain_ctrl_t ctrl_i,
  output dsa_pkg::digit_t      lo_o,
  output dsa_pkg::digit_t      hi_o
);

  dsa_pkg::digit_t q   [dsa_pkg::ChainDepth];
  dsa_pkg::digit_t lo_n[dsa_pkg::ChainDepth];
  dsa_pkg::digit_t hi_n[dsa_pkg::ChainDepth];

  for (genvar i = 0; i < dsa_pkg::ChainDepth; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign lo_n[i] = ctrl_i.lo_in;
    end else begin : g_lo
      assign lo_n[i] = q[i-1];
    end
    if (i == dsa_pkg::ChainDepth - 1) begin : g_hi
      assign hi_n[i] = ctrl_i.hi_in;
    end else begin : g_hi
      assign hi_n[i] = q[i+1];
    end

    dsa_cell u_cell (
      .clk_i     (clk_i),
      .mode_i    (ctrl_i.mode),
      .from_lo_i (lo_n[i]),
      .from_hi_i (hi_n[i]),
      .digit_o   (q[i])
    );
  end

  assign lo_o = q[0];
  assign hi_o = q[dsa_pkg::ChainDepth-1];

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_string_adder_core.sv -----
// Channel   | Direction | Handshake                    | Payload
// request   | in        | start && !busy               | in_i  (dsa_pkg::in_t)
// result    | out       | result_valid_o, one cycle    | res_o (dsa_pkg::res_t)
//
// Digits sit in two 256-cell shift rows, the least significant digit in
// cell 0. The final digit of the second number starts a pass: the carry
// add through the rows, then a shift out of each cell of the 256-cell sum
// row (leading zeros and emitted digits).
// busy is high for the whole pass. After reset the block is idle and both
// numbers are empty. Results cannot be stalled; a word shows for one cycle.
`default_nettype none
`include "assert_macros.svh"

module decimal_string_adder_core (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  dsa_pkg::in_t   in_i,
  output logic           result_valid_o,
  output dsa_pkg::res_t  res_o
);

  localparam dsa_pkg::len_t LenMax   = dsa_pkg::len_t'(dsa_pkg::MaxDigits);
  localparam dsa_pkg::len_t PosLast  = dsa_pkg::len_t'(dsa_pkg::ChainDepth - 1);
  localparam logic [8:0]    RemFull  = 9'(dsa_pkg::ChainDepth);
  localparam logic [3:0]    WordLast = 4'(dsa_pkg::WordDigits - 1);

  dsa_pkg::state_e state_q, state_d;
  dsa_pkg::len_t   len_a_q, len_a_d, len_b_q, len_b_d;
  dsa_pkg::len_t   pos_q, pos_d;
  logic            carry_q, carry_d;
  logic [8:0]      remain_q, remain_d;
  logic [63:0]     word_q, word_d;
  logic [3:0]      wcnt_q, wcnt_d;
  logic            valid_q, valid_d;
  dsa_pkg::res_t   res_q, res_d;

  dsa_pkg::chain_ctrl_t ctrl_a, ctrl_b, ctrl_s;
  dsa_pkg::digit_t a_lo, b_lo, s_lo, a_hi, b_hi, s_hi;

  logic            accept;
  dsa_pkg::digit_t in_digit;
  dsa_pkg::digit_t a_dig, b_dig, sum_dig;
  logic [4:0]      total;
  logic            carry_nx;
  logic            skip_zero, flush;
  logic [3:0]      nib;
  logic [63:0]     word_nx;

  assign accept   = start && !busy;
  assign in_digit = (in_i.digit > 4'd9) ? 4'd9 : in_i.digit;

  // Digit of each operand at the current position, zero past its length.
  assign a_dig    = (pos_q < len_a_q) ? a_lo : 4'd0;
  assign b_dig    = (pos_q < len_b_q) ? b_lo : 4'd0;
  assign total    = {1'b0, a_dig} + {1'b0, b_dig} + {4'd0, carry_q};
  assign carry_nx = total > 5'd9;
  assign sum_dig  = carry_nx ? 4'(total - 5'd10) : total[3:0];

  assign skip_zero = (s_hi == 4'd0) && (remain_q > 9'd1);
  assign flush     = (wcnt_q == WordLast) || (remain_q == 9'd1);
  assign nib       = WordLast - wcnt_q;

  always_comb begin
    word_nx = word_q;
    word_nx[{nib, 2'b00} +: 4] = s_hi;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsa_pkg::ST_IDLE: if (accept && in_i.operand_select && in_i.last_digit) begin
        state_d = dsa_pkg::ST_ADD;
      end
      dsa_pkg::ST_ADD: if (pos_q == PosLast) begin
        state_d = dsa_pkg::ST_SKIP;
      end
      dsa_pkg::ST_SKIP: if (!skip_zero) begin
        state_d = dsa_pkg::ST_EMIT;
      end
      dsa_pkg::ST_EMIT: if (remain_q == 9'd1) begin
        state_d = dsa_pkg::ST_IDLE;
      end
      default: state_d = dsa_pkg::ST_IDLE;
    endcase
  end

  // datapath and chain control
  always_comb begin
    busy     = (state_q != dsa_pkg::ST_IDLE);
    len_a_d  = len_a_q;
    len_b_d  = len_b_q;
    pos_d    = pos_q;
    carry_d  = carry_q;
    remain_d = remain_q;
    word_d   = word_q;
    wcnt_d   = wcnt_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    ctrl_a   = '{mode: dsa_pkg::SHIFT_HOLD, lo_in: in_digit, hi_in: 4'd0};
    ctrl_b   = '{mode: dsa_pkg::SHIFT_HOLD, lo_in: in_digit, hi_in: 4'd0};
    ctrl_s   = '{mode: dsa_pkg::SHIFT_HOLD, lo_in: 4'd0, hi_in: sum_dig};
    unique case (state_q)
      dsa_pkg::ST_IDLE: begin
        if (accept) begin
          pos_d   = '0;
          carry_d = 1'b0;
          if (!in_i.operand_select) begin
            if (len_a_q < LenMax) begin
              ctrl_a.mode = dsa_pkg::SHIFT_UP;
              len_a_d     = len_a_q + 8'd1;
            end
          end else if (len_b_q < LenMax) begin
            ctrl_b.mode = dsa_pkg::SHIFT_UP;
            len_b_d     = len_b_q + 8'd1;
          end
        end
      end
      dsa_pkg::ST_ADD: begin
        ctrl_a.mode = dsa_pkg::SHIFT_DOWN;
        ctrl_b.mode = dsa_pkg::SHIFT_DOWN;
        ctrl_s.mode = dsa_pkg::SHIFT_DOWN;
        pos_d       = pos_q + 8'd1;
        carry_d     = carry_nx;
        if (pos_q == PosLast) begin
          len_a_d  = '0;
          len_b_d  = '0;
          remain_d = RemFull;
          word_d   = '0;
          wcnt_d   = '0;
        end
      end
      dsa_pkg::ST_SKIP: begin
        if (skip_zero) begin
          ctrl_s.mode = dsa_pkg::SHIFT_UP;
          remain_d    = remain_q - 9'd1;
        end
      end
      dsa_pkg::ST_EMIT: begin
        ctrl_s.mode = dsa_pkg::SHIFT_UP;
        remain_d    = remain_q - 9'd1;
        if (flush) begin
          valid_d = 1'b1;
          res_d   = '{sum_digits_bcd: word_nx,
                      digit_count:    {1'b0, wcnt_q} + 5'd1,
                      last_word:      remain_q == 9'd1};
          word_d  = '0;
          wcnt_d  = '0;
        end else begin
          word_d = word_nx;
          wcnt_d = wcnt_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsa_pkg::ST_IDLE;
      len_a_q <= '0;
      len_b_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    carry_q  <= carry_d;
    remain_q <= remain_d;
    word_q   <= word_d;
    wcnt_q   <= wcnt_d;
    res_q    <= res_d;
  end

  dsa_chain u_row_a (.clk_i(clk_i), .ctrl_i(ctrl_a), .lo_o(a_lo), .hi_o(a_hi));
  dsa_chain u_row_b (.clk_i(clk_i), .ctrl_i(ctrl_b), .lo_o(b_lo), .hi_o(b_hi));
  dsa_chain u_row_s (.clk_i(clk_i), .ctrl_i(ctrl_s), .lo_o(s_lo), .hi_o(s_hi));

  assign result_valid_o = valid_q;
  assign res_o          = res_q;

  `ASSERT_CLK(a_strobe_from_emit, result_valid_o |-> $past(state_q == dsa_pkg::ST_EMIT), "result without emit")
  `ASSERT_CLK(a_count_range, result_valid_o |-> (res_o.digit_count != 5'd0 && res_o.digit_count <= 5'd16), "bad digit count")
  `ASSERT_CLK(a_last_idles, (result_valid_o && res_o.last_word) |-> !busy, "busy after final word")
  `ASSERT_NEVER(a_lengths_cleared, (state_q == dsa_pkg::ST_EMIT) && ((len_a_q | len_b_q) != 8'd0), "lengths kept")

endmodule

`default_nettype wire

// ----- test/tb_decimal_string_adder_core.sv -----
`timescale 1ns / 1ps

module tb_decimal_string_adder_core;

  localparam int StallLimit = 5000;
  localparam int ReqTarget  = 480;

  typedef enum int {
    STY_ANY,
    STY_NINES,
    STY_ZEROS
  } digit_style_e;

  typedef struct packed {
    dsa_pkg::in_t  req;
    bit            typed;
    dsa_pkg::res_t word;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  dsa_pkg::in_t  in_i;
  logic          result_valid_o;
  dsa_pkg::res_t res_o;

  decimal_string_adder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  // predictor state
  dsa_pkg::digit_t first_num [dsa_pkg::MaxDigits];
  dsa_pkg::digit_t second_num[dsa_pkg::MaxDigits];
  int              first_len;
  int              second_len;

  dsa_pkg::res_t   sum_words[$];
  dsa_pkg::res_t   sum_words_due[$];
  dsa_pkg::res_t   want;
  row_t            plan[$];
  int              errors;
  int              idle_cycles;
  int              reqs_sent;
  bit              no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Loads one digit; on the second number's final digit, fills sum_words with
  // the packed sum and clears both numbers.
  function automatic void predict_digit(dsa_pkg::in_t r);
    dsa_pkg::digit_t d;
    int              width;
    int              carry;
    int              t;
    int              da;
    int              db;
    int              ndig;
    int              k;
    int              cnt;
    int              total[dsa_pkg::MaxDigits + 1];
    dsa_pkg::res_t   w;
    sum_words = {};
    d = (r.digit > 4'd9) ? 4'd9 : r.digit;
    if (!r.operand_select) begin
      if (first_len < dsa_pkg::MaxDigits) begin
        first_num[first_len] = d;
        first_len++;
      end
      return;
    end
    if (second_len < dsa_pkg::MaxDigits) begin
      second_num[second_len] = d;
      second_len++;
    end
    if (!r.last_digit) return;
    width = (first_len > second_len) ? first_len : second_len;
    carry = 0;
    for (int p = 0; p <= dsa_pkg::MaxDigits; p++) total[p] = 0;
    for (int p = 0; p < width; p++) begin
      da = (p < first_len) ? int'(first_num[first_len - 1 - p]) : 0;
      db = (p < second_len) ? int'(second_num[second_len - 1 - p]) : 0;
      t = da + db + carry;
      carry = (t > 9) ? 1 : 0;
      total[p] = carry ? t - 10 : t;
    end
    if (carry != 0) begin
      total[width] = 1;
      width++;
    end
    ndig = 1;
    for (int p = 0; p < width; p++) if (total[p] != 0) ndig = p + 1;
    k = 0;
    while (k < ndig) begin
      w = '0;
      cnt = 0;
      while (cnt < dsa_pkg::WordDigits && k < ndig) begin
        w.sum_digits_bcd[4 * (dsa_pkg::WordDigits - 1 - cnt) +: 4] = 4'(total[ndig - 1 - k]);
        cnt++;
        k++;
      end
      w.digit_count = 5'(cnt);
      w.last_word = (k >= ndig);
      sum_words.push_back(w);
    end
    first_len = 0;
    second_len = 0;
  endfunction

  function automatic dsa_pkg::in_t mk_req(logic sel, dsa_pkg::digit_t d, logic last);
    dsa_pkg::in_t r;
    r.operand_select = sel;
    r.digit = d;
    r.last_digit = last;
    return r;
  endfunction

  function automatic row_t dir_row(logic sel, dsa_pkg::digit_t d, logic last,
                                   bit typed = 1'b0,
                                   logic [63:0] bcd = '0, logic [4:0] cnt = '0);
    row_t row;
    row.req = mk_req(sel, d, last);
    row.typed = typed;
    row.word.sum_digits_bcd = bcd;
    row.word.digit_count = cnt;
    row.word.last_word = typed;
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic dsa_pkg::digit_t pick_digit(digit_style_e sty);
    int r;
    r = $urandom_range(0, 15);
    case (sty)
      STY_NINES: return (r == 0) ? 4'd15 : 4'd9;
      STY_ZEROS: return (r < 12) ? 4'd0 : dsa_pkg::digit_t'($urandom_range(0, 15));
      default:   return (r < 2) ? dsa_pkg::digit_t'($urandom_range(10, 15))
                                : dsa_pkg::digit_t'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic issue(dsa_pkg::in_t r, bit typed = 1'b0, dsa_pkg::res_t word = '0);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_digit(r);
    if (typed) sum_words_due.push_back(word);
    else foreach (sum_words[i]) sum_words_due.push_back(sum_words[i]);
    reqs_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sum_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pair(int len_x, int len_y, digit_style_e sty);
    for (int i = 0; i < len_x; i++)
      issue(mk_req(1'b0, pick_digit(sty), (i == len_x - 1) && $urandom_range(0, 1)));
    for (int i = 0; i < len_y; i++)
      issue(mk_req(1'b1, pick_digit(sty), i == len_y - 1));
  endtask

  // result check and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
      if (result_valid_o) begin
        if (sum_words_due.size() == 0) begin
          $display("%0t: expected no word, got bcd=%h count=%0d last=%b", $time,
                   res_o.sum_digits_bcd, res_o.digit_count, res_o.last_word);
          errors++;
        end else begin
          want = sum_words_due.pop_front();
          if (res_o.sum_digits_bcd !== want.sum_digits_bcd) begin
            $display("%0t: sum_digits_bcd expected %h got %h", $time,
                     want.sum_digits_bcd, res_o.sum_digits_bcd);
            errors++;
          end
          if (res_o.digit_count !== want.digit_count) begin
            $display("%0t: digit_count expected %0d got %0d", $time,
                     want.digit_count, res_o.digit_count);
            errors++;
          end
          if (res_o.last_word !== want.last_word) begin
            $display("%0t: last_word expected %b got %b", $time,
                     want.last_word, res_o.last_word);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    in_i        <= '0;
    errors      = 0;
    idle_cycles = 0;
    reqs_sent   = 0;
    no_idle     = 1'b0;
    first_len   = 0;
    second_len  = 0;

    // empty first number, zero second number
    plan.push_back(dir_row(1'b1, 4'd0, 1'b1, 1'b1, 64'h0, 5'd1));
    // 99 + 9, final mark on the first number
    plan.push_back(dir_row(1'b0, 4'd9, 1'b0));
    plan.push_back(dir_row(1'b0, 4'd9, 1'b1));
    plan.push_back(dir_row(1'b1, 4'd9, 1'b1, 1'b1, 64'h1080_0000_0000_0000, 5'd3));
    // digits above nine saturate
    plan.push_back(dir_row(1'b0, 4'd15, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd10, 1'b1, 1'b1, 64'h1800_0000_0000_0000, 5'd2));
    // first number keeps growing after its final mark
    plan.push_back(dir_row(1'b0, 4'd1, 1'b1));
    plan.push_back(dir_row(1'b0, 4'd2, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd3, 1'b1, 1'b1, 64'h1500_0000_0000_0000, 5'd2));
    // interleaved digits
    plan.push_back(dir_row(1'b0, 4'd5, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd5, 1'b0));
    plan.push_back(dir_row(1'b0, 4'd5, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd5, 1'b1, 1'b1, 64'h1100_0000_0000_0000, 5'd3));
    // multi-digit zero sum
    plan.push_back(dir_row(1'b0, 4'd0, 1'b0));
    plan.push_back(dir_row(1'b0, 4'd0, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd0, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd0, 1'b1, 1'b1, 64'h0, 5'd1));
    // leading zeros suppressed
    plan.push_back(dir_row(1'b0, 4'd0, 1'b0));
    plan.push_back(dir_row(1'b0, 4'd7, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd0, 1'b0));
    plan.push_back(dir_row(1'b1, 4'd0, 1'b1, 1'b1, 64'h7000_0000_0000_0000, 5'd1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) issue(plan[i].req, plan[i].typed, plan[i].word);
    drain();

    // overlong second number of nines, final mark lands on a dropped digit;
    // the carry gives a full-width sum (16 words)
    send_pair($urandom_range(1, 5), dsa_pkg::MaxDigits + $urandom_range(1, 2), STY_NINES);
    drain();

    while (reqs_sent < ReqTarget) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 2) begin
        // noise: arbitrary tags and marks
        repeat ($urandom_range(1, 6))
          issue(mk_req(1'($urandom_range(0, 1)), dsa_pkg::digit_t'($urandom_range(0, 15)),
                       1'($urandom_range(0, 3) == 0)));
      end else begin
        send_pair(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(0, 12),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 12),
                  digit_style_e'($urandom_range(0, 2)));
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
